// ===== src/tgw_pkg.sv =====
// Shared types, codes and the heading turn table for the turmite grid walker.
`timescale 1ns / 1ps

package tgw_pkg;

    typedef logic [7:0] t_pos;
    typedef logic [7:0] t_symbol;
    typedef logic [1:0] t_heading;
    typedef logic [1:0] t_turn;
    typedef logic [3:0] t_mstate;

    localparam logic OP_STEP = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    localparam t_heading HD_NORTH = 2'd0;
    localparam t_heading HD_SOUTH = 2'd1;
    localparam t_heading HD_EAST  = 2'd2;
    localparam t_heading HD_WEST  = 2'd3;

    localparam t_turn TURN_LEFT     = 2'd0;
    localparam t_turn TURN_RIGHT    = 2'd1;
    localparam t_turn TURN_STRAIGHT = 2'd2;
    localparam t_turn TURN_BACK     = 2'd3;

    localparam t_symbol  BLANK_SYMBOL  = 8'd32;
    localparam logic [7:0] COLOR_RESET = 8'd1;
    localparam t_heading HEADING_RESET = HD_SOUTH;
    localparam int       SYMBOL_BITS   = 8;
    localparam int       MSTATE_COUNT  = 16;

    typedef struct packed {
        logic     valid;
        t_mstate  next_state;
        t_symbol  new_symbol;
        t_turn    turn;
    } t_rule;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RULE,
        ST_COMMIT,
        ST_LOAD
    } t_state;

    typedef struct packed {
        logic clr_en;
        logic accept;
        logic cell_rd;
        logic rule_rd;
        logic commit_step;
        logic commit_load;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
    } t_sts;

    function automatic t_heading f_turn(input t_turn turn, input t_heading hd);
        t_heading res;
        res = hd;
        unique case (turn)
            TURN_LEFT: begin
                unique case (hd)
                    HD_NORTH: res = HD_WEST;
                    HD_SOUTH: res = HD_EAST;
                    HD_EAST:  res = HD_NORTH;
                    default:  res = HD_SOUTH;
                endcase
            end
            TURN_RIGHT: begin
                unique case (hd)
                    HD_NORTH: res = HD_EAST;
                    HD_SOUTH: res = HD_WEST;
                    HD_EAST:  res = HD_SOUTH;
                    default:  res = HD_NORTH;
                endcase
            end
            TURN_STRAIGHT: begin
                res = hd;
            end
            default: begin
                unique case (hd)
                    HD_NORTH: res = HD_SOUTH;
                    HD_SOUTH: res = HD_NORTH;
                    HD_EAST:  res = HD_WEST;
                    default:  res = HD_EAST;
                endcase
            end
        endcase
        return res;
    endfunction

endpackage

// ===== src/turmite_grid_walker_core.sv =====
// Top level of the turmite grid walker: controller plus datapath.
`timescale 1ns / 1ps
//
// Input channel (i_valid / o_stall) carries one word per item: operation 0
// steps the walker once, operation 1 loads the rule slot keyed by
// rule_state and rule_symbol. Output channel (o_valid / i_stall) returns one
// word per item with the walker position, heading and state after it.
// A step reads the grid cell on the accept edge and the rule table in
// the next cycle; the cell write, walker update and output load happen in
// the commit state once the output word is free. The next item is accepted
// in the cycle after the result is loaded, so items do not overlap, set by
// the chain of grid read, rule read and grid write through single-port
// accesses. After reset a clearing pass blanks the grid and invalidates the
// rule table, one entry of each per cycle, while a counter runs through
// 2^max(2*GRID_BITS, rule address bits) values (65536 at the defaults);
// o_stall stays high meanwhile. The color register is written with
// i_cfg_wr_en; the user is to write it only while the block is idle,
// which the block itself does not enforce. While the receiver stalls, the
// result word holds and the next item may still be accepted; it then waits
// in its last cycle until the word is taken.
//
module turmite_grid_walker_core #(
    parameter int GRID_BITS  = 8,
    parameter int NUM_STATES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_operation,
    input  logic [3:0] i_rule_state,
    input  logic [7:0] i_rule_symbol,
    input  logic [3:0] i_rule_next_state,
    input  logic [7:0] i_rule_write_symbol,
    input  logic [1:0] i_rule_turn,
    input  logic       i_rule_enable,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_pos_x,
    output logic [7:0] o_pos_y,
    output logic [1:0] o_heading_out,
    output logic [3:0] o_machine_state_out,
    output logic [7:0] o_symbol_read,
    output logic       o_rule_fired,
    output logic [7:0] o_symbol_written
);

    tgw_pkg::t_cmd cmd;
    tgw_pkg::t_sts sts;

    tgw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    tgw_datapath #(
        .GRID_BITS  (GRID_BITS),
        .NUM_STATES (NUM_STATES)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_wr_data       (i_cfg_wr_data),
        .i_rule_state        (i_rule_state),
        .i_rule_symbol       (i_rule_symbol),
        .i_rule_next_state   (i_rule_next_state),
        .i_rule_write_symbol (i_rule_write_symbol),
        .i_rule_turn         (i_rule_turn),
        .i_rule_enable       (i_rule_enable),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .o_pos_x             (o_pos_x),
        .o_pos_y             (o_pos_y),
        .o_heading_out       (o_heading_out),
        .o_machine_state_out (o_machine_state_out),
        .o_symbol_read       (o_symbol_read),
        .o_rule_fired        (o_rule_fired),
        .o_symbol_written    (o_symbol_written)
    );

endmodule

// ===== src/tgw_ctrl.sv =====
// Controller state machine: clearing pass, item sequencing and output word valid.
`timescale 1ns / 1ps

module tgw_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_operation,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    input  tgw_pkg::t_sts i_sts,
    output tgw_pkg::t_cmd o_cmd
);

    tgw_pkg::t_state r_state;
    tgw_pkg::t_state n_state;
    logic            r_out_vld;
    logic            out_free;

    assign out_free = !r_out_vld || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tgw_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state) inside
            tgw_pkg::ST_CLEAR: begin
                if (i_sts.clr_done) begin
                    n_state = tgw_pkg::ST_IDLE;
                end
            end
            tgw_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = (i_operation == tgw_pkg::OP_LOAD) ? tgw_pkg::ST_LOAD
                                                                 : tgw_pkg::ST_RULE;
                end
            end
            tgw_pkg::ST_RULE: begin
                n_state = tgw_pkg::ST_COMMIT;
            end
            tgw_pkg::ST_COMMIT, tgw_pkg::ST_LOAD: begin
                if (out_free) begin
                    n_state = tgw_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tgw_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd             = '0;
        o_stall           = 1'b1;
        unique case (r_state)
            tgw_pkg::ST_CLEAR: begin
                o_cmd.clr_en = 1'b1;
            end
            tgw_pkg::ST_IDLE: begin
                o_stall       = 1'b0;
                o_cmd.cell_rd = 1'b1;
                o_cmd.accept  = i_valid;
            end
            tgw_pkg::ST_RULE: begin
                o_cmd.rule_rd = 1'b1;
            end
            tgw_pkg::ST_COMMIT: begin
                o_cmd.commit_step = out_free;
            end
            tgw_pkg::ST_LOAD: begin
                o_cmd.commit_load = out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (o_cmd.commit_step || o_cmd.commit_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_valid = r_out_vld;

endmodule

// ===== src/tgw_datapath.sv =====
// Datapath: walker registers, grid and rule memories, output word register.
`timescale 1ns / 1ps

module tgw_datapath #(
    parameter int GRID_BITS  = 8,
    parameter int NUM_STATES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [7:0]       i_cfg_wr_data,
    input  tgw_pkg::t_mstate i_rule_state,
    input  tgw_pkg::t_symbol i_rule_symbol,
    input  tgw_pkg::t_mstate i_rule_next_state,
    input  tgw_pkg::t_symbol i_rule_write_symbol,
    input  tgw_pkg::t_turn   i_rule_turn,
    input  logic             i_rule_enable,
    input  tgw_pkg::t_cmd    i_cmd,
    output tgw_pkg::t_sts    o_sts,
    output tgw_pkg::t_pos    o_pos_x,
    output tgw_pkg::t_pos    o_pos_y,
    output tgw_pkg::t_heading o_heading_out,
    output tgw_pkg::t_mstate o_machine_state_out,
    output tgw_pkg::t_symbol o_symbol_read,
    output logic             o_rule_fired,
    output tgw_pkg::t_symbol o_symbol_written
);

    localparam int EFF_STATES = (NUM_STATES > tgw_pkg::MSTATE_COUNT) ?
                                tgw_pkg::MSTATE_COUNT : NUM_STATES;
    localparam int ST_BITS    = $clog2(EFF_STATES);
    localparam int RULE_AW    = ST_BITS + tgw_pkg::SYMBOL_BITS;
    localparam int RULE_DEPTH = 1 << RULE_AW;
    localparam int CELL_AW    = 2 * GRID_BITS;
    localparam int CELL_COUNT = 1 << CELL_AW;
    localparam int CLR_BITS   = (CELL_AW > RULE_AW) ? CELL_AW : RULE_AW;

    tgw_pkg::t_symbol  r_cell_sym_mem [CELL_COUNT];
    logic [7:0]        r_cell_color_mem [CELL_COUNT];
    tgw_pkg::t_rule    r_rule_mem [RULE_DEPTH];

    logic [GRID_BITS-1:0] r_x;
    logic [GRID_BITS-1:0] r_y;
    logic [GRID_BITS-1:0] n_x;
    logic [GRID_BITS-1:0] n_y;
    tgw_pkg::t_heading    r_hd;
    tgw_pkg::t_heading    n_hd;
    tgw_pkg::t_mstate     r_wst;
    tgw_pkg::t_mstate     n_wst;
    logic [7:0]           r_color;
    logic [CLR_BITS-1:0]  r_clr_cnt;

    tgw_pkg::t_symbol  r_cell_q;
    tgw_pkg::t_rule    r_rule_q;
    logic              r_rule_ok;

    tgw_pkg::t_mstate  r_ld_state;
    tgw_pkg::t_symbol  r_ld_sym;
    tgw_pkg::t_rule    r_ld_rule;

    logic              clr_cell_hit;
    logic              clr_rule_hit;
    logic              ld_ok;
    logic              fired;
    logic [CELL_AW-1:0] cur_addr;
    logic [RULE_AW-1:0] rd_rule_addr;
    logic [RULE_AW-1:0] ld_rule_addr;

    assign cur_addr     = {r_y, r_x};
    assign rd_rule_addr = {r_wst[ST_BITS-1:0], r_cell_q};
    assign ld_rule_addr = {r_ld_state[ST_BITS-1:0], r_ld_sym};
    assign clr_cell_hit = (32'(r_clr_cnt) < CELL_COUNT);
    assign clr_rule_hit = (32'(r_clr_cnt) < RULE_DEPTH);
    assign ld_ok        = (32'(r_ld_state) < NUM_STATES);
    assign fired        = r_rule_ok && r_rule_q.valid;
    assign o_sts.clr_done = &r_clr_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr_en) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= tgw_pkg::COLOR_RESET;
        end else if (i_cfg_wr_en) begin
            r_color <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ld_state            <= i_rule_state;
            r_ld_sym              <= i_rule_symbol;
            r_ld_rule.valid       <= i_rule_enable;
            r_ld_rule.next_state  <= i_rule_next_state;
            r_ld_rule.new_symbol  <= i_rule_write_symbol;
            r_ld_rule.turn        <= i_rule_turn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_en && clr_cell_hit) begin
            r_cell_sym_mem[r_clr_cnt[CELL_AW-1:0]]   <= tgw_pkg::BLANK_SYMBOL;
            r_cell_color_mem[r_clr_cnt[CELL_AW-1:0]] <= '0;
        end else if (i_cmd.commit_step && fired) begin
            r_cell_sym_mem[cur_addr]   <= r_rule_q.new_symbol;
            r_cell_color_mem[cur_addr] <= r_color;
        end
        if (i_cmd.cell_rd) begin
            r_cell_q <= r_cell_sym_mem[cur_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_en && clr_rule_hit) begin
            r_rule_mem[r_clr_cnt[RULE_AW-1:0]] <= '0;
        end else if (i_cmd.commit_load && ld_ok) begin
            r_rule_mem[ld_rule_addr] <= r_ld_rule;
        end
        if (i_cmd.rule_rd) begin
            r_rule_q  <= r_rule_mem[rd_rule_addr];
            r_rule_ok <= (32'(r_wst) < NUM_STATES);
        end
    end

    always_comb begin
        n_hd  = fired ? tgw_pkg::f_turn(r_rule_q.turn, r_hd) : r_hd;
        n_wst = fired ? r_rule_q.next_state : r_wst;
        n_x   = r_x;
        n_y   = r_y;
        unique case (n_hd)
            tgw_pkg::HD_NORTH: n_y = r_y - 1'b1;
            tgw_pkg::HD_SOUTH: n_y = r_y + 1'b1;
            tgw_pkg::HD_EAST:  n_x = r_x + 1'b1;
            default:           n_x = r_x - 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x   <= '0;
            r_y   <= '0;
            r_hd  <= tgw_pkg::HEADING_RESET;
            r_wst <= '0;
        end else if (i_cmd.commit_step) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_hd  <= n_hd;
            r_wst <= n_wst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit_step) begin
            o_pos_x             <= tgw_pkg::t_pos'(n_x);
            o_pos_y             <= tgw_pkg::t_pos'(n_y);
            o_heading_out       <= n_hd;
            o_machine_state_out <= n_wst;
            o_symbol_read       <= r_cell_q;
            o_rule_fired        <= fired;
            o_symbol_written    <= fired ? r_rule_q.new_symbol : r_cell_q;
        end else if (i_cmd.commit_load) begin
            o_pos_x             <= tgw_pkg::t_pos'(r_x);
            o_pos_y             <= tgw_pkg::t_pos'(r_y);
            o_heading_out       <= r_hd;
            o_machine_state_out <= r_wst;
            o_symbol_read       <= '0;
            o_rule_fired        <= 1'b0;
            o_symbol_written    <= '0;
        end
    end

endmodule

// ===== src/tgw_checker.sv =====
// Port-level checker for the turmite grid walker and its bind.
`timescale 1ns / 1ps

module tgw_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_pos_x,
    input logic [7:0] o_pos_y,
    input logic [1:0] o_heading_out,
    input logic [3:0] o_machine_state_out,
    input logic [7:0] o_symbol_read,
    input logic       o_rule_fired,
    input logic [7:0] o_symbol_written
);

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output word valid after reset");

    a_stalled_word_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pos_x) && $stable(o_pos_y)
            && $stable(o_heading_out) && $stable(o_machine_state_out)
            && $stable(o_symbol_read) && $stable(o_rule_fired)
            && $stable(o_symbol_written))
        else $error("stalled output word changed");

    a_one_item_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second word accepted while an item is in work");

    a_unfired_keeps_symbol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_rule_fired |-> o_symbol_written == o_symbol_read)
        else $error("symbol changed without a rule firing");

endmodule

bind turmite_grid_walker_core tgw_checker u_tgw_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_valid             (i_valid),
    .o_stall             (o_stall),
    .o_valid             (o_valid),
    .i_stall             (i_stall),
    .o_pos_x             (o_pos_x),
    .o_pos_y             (o_pos_y),
    .o_heading_out       (o_heading_out),
    .o_machine_state_out (o_machine_state_out),
    .o_symbol_read       (o_symbol_read),
    .o_rule_fired        (o_rule_fired),
    .o_symbol_written    (o_symbol_written)
);

// ===== tb/tb_turmite_grid_walker_core.sv =====
// Self-checking testbench for turmite_grid_walker_core with its own walker and grid model.
`timescale 1ns / 1ps

module tb_turmite_grid_walker_core;

    typedef struct packed {
        logic             op;
        tgw_pkg::t_mstate rstate;
        tgw_pkg::t_symbol rsym;
        tgw_pkg::t_mstate rnext;
        tgw_pkg::t_symbol rwrite;
        tgw_pkg::t_turn   rturn;
        logic             ren;
    } t_walk_cmd;

    typedef struct packed {
        tgw_pkg::t_pos     x;
        tgw_pkg::t_pos     y;
        tgw_pkg::t_heading heading;
        tgw_pkg::t_mstate  mstate;
        tgw_pkg::t_symbol  sym_read;
        logic              fired;
        tgw_pkg::t_symbol  sym_written;
    } t_walk_report;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY
    } t_rx_mode;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_wr_en;
    logic [7:0] i_cfg_wr_data;
    logic       i_valid;
    logic       o_stall;
    logic       i_operation;
    logic [3:0] i_rule_state;
    logic [7:0] i_rule_symbol;
    logic [3:0] i_rule_next_state;
    logic [7:0] i_rule_write_symbol;
    logic [1:0] i_rule_turn;
    logic       i_rule_enable;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_pos_x;
    logic [7:0] o_pos_y;
    logic [1:0] o_heading_out;
    logic [3:0] o_machine_state_out;
    logic [7:0] o_symbol_read;
    logic       o_rule_fired;
    logic [7:0] o_symbol_written;

    turmite_grid_walker_core dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_wr_data       (i_cfg_wr_data),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_operation         (i_operation),
        .i_rule_state        (i_rule_state),
        .i_rule_symbol       (i_rule_symbol),
        .i_rule_next_state   (i_rule_next_state),
        .i_rule_write_symbol (i_rule_write_symbol),
        .i_rule_turn         (i_rule_turn),
        .i_rule_enable       (i_rule_enable),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_pos_x             (o_pos_x),
        .o_pos_y             (o_pos_y),
        .o_heading_out       (o_heading_out),
        .o_machine_state_out (o_machine_state_out),
        .o_symbol_read       (o_symbol_read),
        .o_rule_fired        (o_rule_fired),
        .o_symbol_written    (o_symbol_written)
    );

    // new heading, indexed by [turn][old heading]
    tgw_pkg::t_heading turn_lut [4][4] = '{
        '{tgw_pkg::HD_WEST,  tgw_pkg::HD_EAST,  tgw_pkg::HD_NORTH, tgw_pkg::HD_SOUTH},
        '{tgw_pkg::HD_EAST,  tgw_pkg::HD_WEST,  tgw_pkg::HD_SOUTH, tgw_pkg::HD_NORTH},
        '{tgw_pkg::HD_NORTH, tgw_pkg::HD_SOUTH, tgw_pkg::HD_EAST,  tgw_pkg::HD_WEST},
        '{tgw_pkg::HD_SOUTH, tgw_pkg::HD_NORTH, tgw_pkg::HD_WEST,  tgw_pkg::HD_EAST}
    };

    tgw_pkg::t_symbol  grid_sym   [0:65535];
    logic [7:0]        grid_color [0:65535];
    tgw_pkg::t_rule    rule_slots [0:4095];
    tgw_pkg::t_pos     wk_x;
    tgw_pkg::t_pos     wk_y;
    tgw_pkg::t_heading wk_head;
    tgw_pkg::t_mstate  wk_state;
    logic [7:0]        color_reg;

    t_walk_report pending_reports [$];
    int           mismatches;
    int           words_sent;
    int           reports_seen;
    int           burst_left;
    bit           tx_gaps_on;
    int           stall_hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic t_walk_report advance_walker(t_walk_cmd c);
        t_walk_report   r;
        tgw_pkg::t_rule slot;
        logic [15:0]    cell_idx;
        r = '0;
        if (c.op == tgw_pkg::OP_LOAD) begin
            if (int'(c.rstate) < tgw_pkg::MSTATE_COUNT) begin
                rule_slots[{c.rstate, c.rsym}] = '{valid: c.ren, next_state: c.rnext,
                                                   new_symbol: c.rwrite, turn: c.rturn};
            end
        end else begin
            cell_idx = {wk_y, wk_x};
            r.sym_read = grid_sym[cell_idx];
            r.sym_written = r.sym_read;
            slot = rule_slots[{wk_state, r.sym_read}];
            if (int'(wk_state) < tgw_pkg::MSTATE_COUNT && slot.valid) begin
                wk_head = turn_lut[slot.turn][wk_head];
                wk_state = slot.next_state;
                grid_sym[cell_idx] = slot.new_symbol;
                grid_color[cell_idx] = color_reg;
                r.sym_written = slot.new_symbol;
                r.fired = 1'b1;
            end
            case (wk_head)
                tgw_pkg::HD_NORTH: wk_y = wk_y - 1'b1;
                tgw_pkg::HD_SOUTH: wk_y = wk_y + 1'b1;
                tgw_pkg::HD_EAST:  wk_x = wk_x + 1'b1;
                default:           wk_x = wk_x - 1'b1;
            endcase
        end
        r.x = wk_x;
        r.y = wk_y;
        r.heading = wk_head;
        r.mstate = wk_state;
        return r;
    endfunction

    function automatic t_walk_cmd random_cmd(logic op);
        t_walk_cmd   c;
        logic [31:0] bits;
        bits = $urandom;
        c = bits[$bits(t_walk_cmd)-1:0];
        c.op = op;
        return c;
    endfunction

    function automatic t_walk_cmd rule_load(tgw_pkg::t_mstate st, tgw_pkg::t_symbol sym,
                                            tgw_pkg::t_mstate nxt, tgw_pkg::t_symbol wr,
                                            tgw_pkg::t_turn turn, logic en);
        t_walk_cmd c;
        c = '{op: tgw_pkg::OP_LOAD, rstate: st, rsym: sym, rnext: nxt, rwrite: wr,
              rturn: turn, ren: en};
        return c;
    endfunction

    task automatic send_word(t_walk_cmd c);
        bit           taken;
        t_walk_report rep;
        if (tx_gaps_on && burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        if (burst_left > 0) burst_left--;
        i_valid             <= 1'b1;
        i_operation         <= c.op;
        i_rule_state        <= c.rstate;
        i_rule_symbol       <= c.rsym;
        i_rule_next_state   <= c.rnext;
        i_rule_write_symbol <= c.rwrite;
        i_rule_turn         <= c.rturn;
        i_rule_enable       <= c.ren;
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
        rep = advance_walker(c);
        pending_reports = {pending_reports, rep};
        words_sent++;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_color(logic [7:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        color_reg = value;
    endtask

    task automatic compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("word %0d: %s expected %0d, got %0d", reports_seen, name, want, got);
            end
        end
    endtask

    task automatic test_wrap_and_rules();
        send_word(rule_load(4'd0, tgw_pkg::BLANK_SYMBOL, 4'd15, 8'hFF,
                            tgw_pkg::TURN_RIGHT, 1'b1));
        send_word(random_cmd(tgw_pkg::OP_STEP));
        send_word(rule_load(4'd15, tgw_pkg::BLANK_SYMBOL, 4'd0, 8'h00,
                            tgw_pkg::TURN_RIGHT, 1'b1));
        send_word(random_cmd(tgw_pkg::OP_STEP));
        send_word(random_cmd(tgw_pkg::OP_STEP));
        send_word(rule_load(4'd15, tgw_pkg::BLANK_SYMBOL, 4'd15, 8'hFF,
                            tgw_pkg::TURN_RIGHT, 1'b0));
        send_word(random_cmd(tgw_pkg::OP_STEP));
        send_word(rule_load(4'd15, tgw_pkg::BLANK_SYMBOL, 4'd15, 8'h00,
                            tgw_pkg::TURN_RIGHT, 1'b1));
        send_word(random_cmd(tgw_pkg::OP_STEP));
        send_word(rule_load(4'd15, tgw_pkg::BLANK_SYMBOL, 4'd15, tgw_pkg::BLANK_SYMBOL,
                            tgw_pkg::TURN_STRAIGHT, 1'b1));
        send_word(random_cmd(tgw_pkg::OP_STEP));
        send_word(rule_load(4'd15, tgw_pkg::BLANK_SYMBOL, 4'd0, 8'h41,
                            tgw_pkg::TURN_LEFT, 1'b1));
        send_word(random_cmd(tgw_pkg::OP_STEP));
        send_word(rule_load(4'd0, 8'h00, 4'd0, 8'h00, tgw_pkg::TURN_LEFT, 1'b0));
        send_word(rule_load(4'd15, 8'hFF, 4'd15, 8'hFF, tgw_pkg::TURN_BACK, 1'b1));
        send_word(random_cmd(tgw_pkg::OP_STEP));
        send_word(rule_load(4'd15, tgw_pkg::BLANK_SYMBOL, 4'd15, 8'h00,
                            tgw_pkg::TURN_BACK, 1'b1));
        send_word(random_cmd(tgw_pkg::OP_STEP));
        send_word(random_cmd(tgw_pkg::OP_STEP));
        send_word(random_cmd(tgw_pkg::OP_STEP));
        send_word(random_cmd(tgw_pkg::OP_STEP));
        drain_results();
    endtask

    task automatic test_full_backpressure();
        tx_gaps_on = 1'b0;
        stall_hold_cycles = 300;
        repeat (40) send_word(random_cmd(tgw_pkg::OP_STEP));
        tx_gaps_on = 1'b1;
        drain_results();
    endtask

    task automatic test_random_turmites();
        tgw_pkg::t_mstate st_pool [4];
        tgw_pkg::t_symbol sym_pool [4];
        int               n_st;
        int               n_sym;
        int               phase;
        phase = 0;
        while (words_sent < 1000) begin
            case (phase % 3)
                0:       write_color(8'h00);
                1:       write_color(8'hFF);
                default: write_color(8'($urandom_range(0, 255)));
            endcase
            n_st = $urandom_range(1, 4);
            n_sym = $urandom_range(1, 4);
            st_pool[0] = wk_state;
            sym_pool[0] = tgw_pkg::BLANK_SYMBOL;
            for (int i = 1; i < 4; i++) begin
                st_pool[i] = 4'($urandom_range(0, 15));
                sym_pool[i] = 8'($urandom_range(0, 255));
            end
            for (int s = 0; s < n_st; s++) begin
                for (int y = 0; y < n_sym; y++) begin
                    send_word(rule_load(st_pool[s], sym_pool[y],
                                        st_pool[$urandom_range(0, n_st - 1)],
                                        sym_pool[$urandom_range(0, n_sym - 1)],
                                        tgw_pkg::t_turn'($urandom_range(0, 3)),
                                        $urandom_range(0, 7) != 0));
                end
            end
            repeat ($urandom_range(40, 140)) begin
                send_word(random_cmd(($urandom_range(0, 19) == 0) ? tgw_pkg::OP_LOAD
                                                                  : tgw_pkg::OP_STEP));
            end
            drain_results();
            phase++;
        end
    endtask

    initial begin
        t_rx_mode rx_mode;
        int       mode_left;
        mode_left = 0;
        rx_mode = RX_FREE;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_hold_cycles > 0) begin
                i_stall <= 1'b1;
                stall_hold_cycles--;
            end else begin
                if (mode_left == 0) begin
                    rx_mode = t_rx_mode'($urandom_range(0, 2));
                    mode_left = $urandom_range(20, 150);
                end
                mode_left--;
                case (rx_mode)
                    RX_FREE:  i_stall <= 1'b0;
                    RX_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                    default:  i_stall <= ($urandom_range(0, 1) == 0);
                endcase
            end
        end
    end

    initial begin
        t_walk_report got;
        t_walk_report want;
        forever begin
            @(negedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                got = '{x: o_pos_x, y: o_pos_y, heading: o_heading_out,
                        mstate: o_machine_state_out, sym_read: o_symbol_read,
                        fired: o_rule_fired, sym_written: o_symbol_written};
                if (pending_reports.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("word %0d: unexpected result", reports_seen);
                end else begin
                    want = pending_reports.pop_front();
                    compare_field("pos_x", want.x, got.x);
                    compare_field("pos_y", want.y, got.y);
                    compare_field("heading_out", want.heading, got.heading);
                    compare_field("machine_state_out", want.mstate, got.mstate);
                    compare_field("symbol_read", want.sym_read, got.sym_read);
                    compare_field("rule_fired", want.fired, got.fired);
                    compare_field("symbol_written", want.sym_written, got.sym_written);
                end
                reports_seen++;
            end
        end
    end

    initial begin
        mismatches = 0;
        words_sent = 0;
        reports_seen = 0;
        burst_left = 0;
        tx_gaps_on = 1'b1;
        stall_hold_cycles = 0;
        wk_x = '0;
        wk_y = '0;
        wk_head = tgw_pkg::HEADING_RESET;
        wk_state = '0;
        color_reg = tgw_pkg::COLOR_RESET;
        for (int i = 0; i < 65536; i++) begin
            grid_sym[i] = tgw_pkg::BLANK_SYMBOL;
            grid_color[i] = '0;
        end
        for (int i = 0; i < 4096; i++) rule_slots[i] = '0;

        i_rst_n             <= 1'b0;
        i_cfg_wr_en         <= 1'b0;
        i_cfg_wr_data       <= '0;
        i_valid             <= 1'b0;
        i_operation         <= tgw_pkg::OP_STEP;
        i_rule_state        <= '0;
        i_rule_symbol       <= '0;
        i_rule_next_state   <= '0;
        i_rule_write_symbol <= '0;
        i_rule_turn         <= tgw_pkg::TURN_LEFT;
        i_rule_enable       <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(negedge i_clk); while (o_stall);
        @(posedge i_clk);

        write_color(8'hFF);
        test_wrap_and_rules();
        test_full_backpressure();
        test_random_turmites();

        drain_results();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
